>>> sv/p3ik_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// p3ik_pkg: shared types and constants of the planar three-link IK core
// Fixed-point formats, the arctangent table, queue word and unit interfaces.
// ----------------------------------------------------------------------------
package p3ik_pkg;

  // Default CORDIC iteration count, and the length of the arctangent table.
  localparam int CORDIC_ITERATIONS_DEF = 16;
  localparam int TAB_LEN = 24;
  localparam int IW = 5;

  // Field widths.
  localparam int CW = 46;   // CORDIC vector width
  localparam int ZW = 24;   // CORDIC angle width, 20 fraction bits
  localparam int LW = 13;   // link length width
  localparam int MA = 33;   // multiplier operand A
  localparam int MB = 29;   // multiplier operand B
  localparam int MP = MA + MB;
  localparam int NW = 35;   // law-of-cosines numerator
  localparam int DW = 27;   // law-of-cosines denominator
  localparam int SQ_IN_W = 54;
  localparam int SQ_W = 27;
  localparam int SQ_STEPS = SQ_IN_W / 2;
  localparam int WW = 18;   // wrist point coordinates
  localparam int AW = 18;   // output angle width
  localparam int QW = 21;   // angle sums before saturation

  // Angle and gain constants.
  localparam logic signed [ZW-1:0] PI_Q20 = 24'sd3294198;
  localparam logic signed [ZW-1:0] HALF_PI_Q20 = 24'sd1647099;
  localparam logic signed [CW-1:0] GAIN_INV_Q30 = 46'sd652032874;
  localparam logic signed [ZW-1:0] Q2_MAX = 24'sd25736;

  // Configuration register indexes.
  localparam logic [1:0] REG_UPPER = 2'd0;
  localparam logic [1:0] REG_MIDDLE = 2'd1;
  localparam logic [1:0] REG_TOOL = 2'd2;
  localparam logic [1:0] REG_OFFSET = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [LW-1:0] UPPER_RESET = 13'd1638;
  localparam logic [LW-1:0] MIDDLE_RESET = 13'd1638;
  localparam logic [LW-1:0] TOOL_RESET = 13'd819;
  localparam logic signed [15:0] OFFSET_RESET = 16'sd12868;

  // Queue word from the front end: target and folded tool angle.
  typedef struct packed {
    logic signed [15:0]   x;
    logic signed [15:0]   y;
    logic signed [15:0]   th;
    logic signed [ZW-1:0] t;
    logic                 neg;
  } q_item_t;

  typedef struct packed {
    logic [LW-1:0]      l1;
    logic [LW-1:0]      l2;
    logic [LW-1:0]      l3;
    logic signed [15:0] off;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic                 vectoring;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_rsp_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_NORM,
    CS_ITER
  } cordic_state_t;

  typedef enum logic [4:0] {
    BS_IDLE,
    BS_ROT,
    BS_ROT_WAIT,
    BS_MUL_C,
    BS_MUL_S,
    BS_MUL_XX,
    BS_MUL_YY,
    BS_MUL_L11,
    BS_MUL_L22,
    BS_MUL_L12,
    BS_CHECK,
    BS_MUL_DD,
    BS_MUL_NN,
    BS_SQRT,
    BS_SQRT_WAIT,
    BS_ELBOW,
    BS_ELBOW_WAIT,
    BS_WDIR,
    BS_WDIR_WAIT,
    BS_MUL_LS,
    BS_MUL_LD,
    BS_MUL_LN,
    BS_MUL_SUM,
    BS_SHLD,
    BS_SHLD_WAIT,
    BS_FINISH
  } back_state_t;

  // Arctangent of 2^-i in Q.20, rounded to nearest.
  function automatic logic [19:0] arc_tab(input logic [IW-1:0] idx);
    logic [19:0] v;
    case (idx)
      5'd0:    v = 20'd823550;
      5'd1:    v = 20'd486170;
      5'd2:    v = 20'd256879;
      5'd3:    v = 20'd130396;
      5'd4:    v = 20'd65451;
      5'd5:    v = 20'd32757;
      5'd6:    v = 20'd16383;
      5'd7:    v = 20'd8192;
      5'd8:    v = 20'd4096;
      5'd9:    v = 20'd2048;
      5'd10:   v = 20'd1024;
      5'd11:   v = 20'd512;
      5'd12:   v = 20'd256;
      5'd13:   v = 20'd128;
      5'd14:   v = 20'd64;
      5'd15:   v = 20'd32;
      5'd16:   v = 20'd16;
      5'd17:   v = 20'd8;
      5'd18:   v = 20'd4;
      5'd19:   v = 20'd2;
      5'd20:   v = 20'd1;
      default: v = 20'd0;
    endcase
    return v;
  endfunction

  // Saturate an angle sum to the signed 18-bit output range.
  function automatic logic signed [AW-1:0] sat18(input logic signed [QW-1:0] v);
    logic signed [AW-1:0] r;
    if (v > QW'(131071)) begin
      r = 18'sd131071;
    end else if (v < -QW'(131072)) begin
      r = -18'sd131072;
    end else begin
      r = AW'(v);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> sv/p3ik_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// p3ik_front: input stage of the IK core
// Accepts target words, folds the tool angle into +/- pi/2 and queues them.
// ----------------------------------------------------------------------------
module p3ik_front import p3ik_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] target_x,
  input  wire logic signed [15:0] target_y,
  input  wire logic signed [15:0] tool_orientation,
  output logic                    q_valid,
  input  wire logic               q_ready,
  output q_item_t                 q_item
);

  localparam int QDEPTH = 2;

  q_item_t            mem [QDEPTH];
  logic               wptr;
  logic               rptr;
  logic [1:0]         count;
  logic               push;
  logic               pop;
  q_item_t            item;
  logic signed [ZW-1:0] t0;

  // Fold the tool angle into the rotation range and remember the half turn.
  always_comb begin
    t0 = ZW'(tool_orientation) <<< 7;
    item.x = target_x;
    item.y = target_y;
    item.th = tool_orientation;
    item.t = t0;
    item.neg = 1'b0;
    if (t0 > HALF_PI_Q20) begin
      item.t = t0 - PI_Q20;
      item.neg = 1'b1;
    end else if (t0 < -HALF_PI_Q20) begin
      item.t = t0 + PI_Q20;
      item.neg = 1'b1;
    end
  end

  assign in_ready = (count != 2'(QDEPTH));
  assign q_valid = (count != 2'd0);
  assign q_item = mem[rptr];
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= item;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

>>> sv/p3ik_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// p3ik_cordic: shared iterative CORDIC unit
// Rotation mode gives cosine and sine; vectoring mode gives atan2 in Q.20.
// ----------------------------------------------------------------------------
module p3ik_cordic import p3ik_pkg::*; #(
  parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cordic_req_t req,
  output cordic_rsp_t      rsp
);

  localparam int NSTEPS = (CORDIC_ITERATIONS > TAB_LEN) ? TAB_LEN :
                          ((CORDIC_ITERATIONS < 1) ? 1 : CORDIC_ITERATIONS);
  localparam logic [IW-1:0] LAST = IW'(NSTEPS - 1);

  cordic_state_t        state;
  cordic_state_t        state_next;
  logic                 done;
  logic                 vec;
  logic [IW-1:0]        iter;
  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [ZW-1:0] z;
  logic signed [ZW-1:0] base;
  logic signed [CW-1:0] mag_y;
  logic signed [CW-1:0] m;
  logic                 below4;
  logic                 below1;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [ZW-1:0] tab;
  logic                 zero_in;

  // Normalization test and micro-rotation terms.
  always_comb begin
    mag_y = y[CW-1] ? -y : y;
    m = (x > mag_y) ? x : mag_y;
    below4 = (m[CW-1:26] == '0);
    below1 = (m[CW-1:30] == '0);
    xs = x >>> iter;
    ys = y >>> iter;
    tab = ZW'($signed({1'b0, arc_tab(iter)}));
    zero_in = (req.x == '0) && (req.y == '0);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      CS_IDLE: begin
        if (req.start) begin
          if (!req.vectoring) begin
            state_next = CS_ITER;
          end else if (!zero_in) begin
            state_next = CS_NORM;
          end
        end
      end
      CS_NORM: begin
        if (!below1) begin
          state_next = CS_ITER;
        end
      end
      CS_ITER: begin
        if (iter == LAST) begin
          state_next = CS_IDLE;
        end
      end
      default: state_next = CS_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= ((state == CS_IDLE) && req.start && req.vectoring && zero_in) ||
              ((state == CS_ITER) && (iter == LAST));
    end
  end

  // Vector and angle datapath.
  always_ff @(posedge clk) begin
    case (state)
      CS_IDLE: begin
        if (req.start) begin
          vec <= req.vectoring;
          iter <= '0;
          if (req.vectoring) begin
            z <= '0;
            if (zero_in) begin
              base <= '0;
              x <= '0;
              y <= '0;
            end else if (req.x < 0) begin
              x <= -req.x;
              y <= -req.y;
              base <= (req.y >= 0) ? PI_Q20 : -PI_Q20;
            end else begin
              x <= req.x;
              y <= req.y;
              base <= '0;
            end
          end else begin
            x <= req.x;
            y <= req.y;
            z <= req.z;
            base <= '0;
          end
        end
      end
      CS_NORM: begin
        if (below4) begin
          x <= x <<< 4;
          y <= y <<< 4;
        end else if (below1) begin
          x <= x <<< 1;
          y <= y <<< 1;
        end
      end
      CS_ITER: begin
        iter <= iter + 1'b1;
        if (vec ? (y >= 0) : (z < 0)) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + tab;
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - tab;
        end
      end
      default: begin
      end
    endcase
  end

  assign rsp.done = done;
  assign rsp.x = x;
  assign rsp.y = y;
  assign rsp.z = z + base;

endmodule
`default_nettype wire

>>> sv/p3ik_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// p3ik_isqrt: digit-serial integer square root
// Produces one root bit per cycle; the result is the floor of the root.
// ----------------------------------------------------------------------------
module p3ik_isqrt import p3ik_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [SQ_IN_W-1:0] radicand,
  output logic                    done,
  output logic [SQ_W-1:0]         root
);

  localparam int RW = SQ_W + 3;

  logic               busy;
  logic [IW-1:0]      cnt;
  logic [SQ_IN_W-1:0] vsh;
  logic [RW-1:0]      rem;
  logic [RW-1:0]      rem_sh;
  logic [RW-1:0]      trial;
  logic               ge;

  // One restoring step: bring down two bits and try the next root bit.
  always_comb begin
    rem_sh = {rem[RW-3:0], vsh[SQ_IN_W-1 -: 2]};
    trial = {1'b0, root, 2'b01};
    ge = (rem_sh >= trial);
  end

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == IW'(SQ_STEPS - 1));
      if (start) begin
        busy <= 1'b1;
      end else if (cnt == IW'(SQ_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= '0;
      vsh <= radicand;
      rem <= '0;
      root <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      vsh <= vsh << 2;
      rem <= ge ? (rem_sh - trial) : rem_sh;
      root <= {root[SQ_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

>>> sv/p3ik_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// p3ik_back: solver sequencer of the IK core
// Runs the closed-form elbow solution on one queued word with one shared
// multiplier, the CORDIC unit and the square root unit, and holds the result.
// ----------------------------------------------------------------------------
module p3ik_back import p3ik_pkg::*; #(
  parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cfg_t             cfg,
  input  wire logic             q_valid,
  output logic                  q_ready,
  input  wire q_item_t          q_item,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  reachable,
  output logic signed [AW-1:0]  base_joint_angle,
  output logic [14:0]           elbow_joint_angle,
  output logic signed [AW-1:0]  wrist_joint_angle
);

  localparam logic signed [MP-1:0] ROUND30 = {{(MP - 30){1'b0}}, 1'b1, 29'b0};

  back_state_t          state;
  back_state_t          state_next;
  cordic_req_t          creq;
  cordic_rsp_t          crsp;
  logic                 sq_start;
  logic [SQ_IN_W-1:0]   sq_in;
  logic                 sq_done;
  logic [SQ_W-1:0]      sq_root;

  // Item and intermediate registers.
  logic signed [15:0]   xi;
  logic signed [15:0]   yi;
  logic signed [15:0]   thi;
  logic signed [ZW-1:0] ti;
  logic                 negi;
  logic signed [MA-1:0] c_r;
  logic signed [MA-1:0] s_r;
  logic signed [WW-1:0] xw;
  logic signed [WW-1:0] yw;
  logic signed [NW-1:0] num;
  logic [DW-1:0]        den;
  logic [SQ_IN_W-1:0]   vacc;
  logic [SQ_W-1:0]      sq;
  logic signed [CW-1:0] ya;
  logic signed [CW-1:0] xa;
  logic signed [ZW-1:0] q2z;
  logic signed [ZW-1:0] q1a;
  logic signed [25:0]   q1z;
  logic                 unreach;

  // Shared multiplier.
  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [MP-1:0] prod;

  // Combinational helpers.
  logic signed [MP-1:0] prod_rnd;
  logic [DW-1:0]        den_c;
  logic signed [NW-1:0] den_s;
  logic                 unreach_c;
  logic                 out_free;
  logic signed [MB-1:0] num_n;
  logic signed [ZW-1:0] q2r;
  logic [14:0]          q2c;
  logic signed [25:0]   q1r;
  logic signed [QW-1:0] q3w;
  logic signed [QW-1:0] q1o;

  p3ik_cordic #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_cordic (
    .clk (clk),
    .rst (rst),
    .req (creq),
    .rsp (crsp)
  );

  p3ik_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_in),
    .done     (sq_done),
    .root     (sq_root)
  );

  // Shared terms: rounding of L3 products, reach test, output formatting.
  always_comb begin
    prod_rnd = (prod + ROUND30) >>> 30;
    den_c = {prod[DW-2:0], 1'b0};
    den_s = NW'($signed({1'b0, den_c}));
    unreach_c = (cfg.l1 == '0) || (cfg.l2 == '0) || (num > den_s) || (num < -den_s);
    out_free = !out_valid || out_ready;
    num_n = num[MB-1:0];
    q2r = (q2z + ZW'(64)) >>> 7;
    if (q2r < 0) begin
      q2c = 15'd0;
    end else if (q2r > Q2_MAX) begin
      q2c = 15'(Q2_MAX);
    end else begin
      q2c = q2r[14:0];
    end
    q1r = (q1z + 26'sd64) >>> 7;
    q3w = QW'(thi) - QW'(q1r) - QW'($signed({1'b0, q2c}));
    q1o = QW'(q1r) + QW'(cfg.off);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      BS_IDLE:       if (q_valid) state_next = BS_ROT;
      BS_ROT:        state_next = BS_ROT_WAIT;
      BS_ROT_WAIT:   if (crsp.done) state_next = BS_MUL_C;
      BS_MUL_C:      state_next = BS_MUL_S;
      BS_MUL_S:      state_next = BS_MUL_XX;
      BS_MUL_XX:     state_next = BS_MUL_YY;
      BS_MUL_YY:     state_next = BS_MUL_L11;
      BS_MUL_L11:    state_next = BS_MUL_L22;
      BS_MUL_L22:    state_next = BS_MUL_L12;
      BS_MUL_L12:    state_next = BS_CHECK;
      BS_CHECK:      state_next = unreach_c ? BS_FINISH : BS_MUL_DD;
      BS_MUL_DD:     state_next = BS_MUL_NN;
      BS_MUL_NN:     state_next = BS_SQRT;
      BS_SQRT:       state_next = BS_SQRT_WAIT;
      BS_SQRT_WAIT:  if (sq_done) state_next = BS_ELBOW;
      BS_ELBOW:      state_next = BS_ELBOW_WAIT;
      BS_ELBOW_WAIT: if (crsp.done) state_next = BS_WDIR;
      BS_WDIR:       state_next = BS_WDIR_WAIT;
      BS_WDIR_WAIT:  if (crsp.done) state_next = BS_MUL_LS;
      BS_MUL_LS:     state_next = BS_MUL_LD;
      BS_MUL_LD:     state_next = BS_MUL_LN;
      BS_MUL_LN:     state_next = BS_MUL_SUM;
      BS_MUL_SUM:    state_next = BS_SHLD;
      BS_SHLD:       state_next = BS_SHLD_WAIT;
      BS_SHLD_WAIT:  if (crsp.done) state_next = BS_FINISH;
      BS_FINISH:     if (out_free) state_next = BS_IDLE;
      default:       state_next = BS_IDLE;
    endcase
  end

  // Outputs of the sequencer: queue pop, multiplier operands, unit starts.
  always_comb begin
    q_ready = (state == BS_IDLE);
    mul_a = '0;
    mul_b = '0;
    creq.start = 1'b0;
    creq.vectoring = 1'b1;
    creq.x = '0;
    creq.y = '0;
    creq.z = '0;
    sq_start = (state == BS_SQRT);
    sq_in = vacc - SQ_IN_W'(prod);
    case (state)
      BS_ROT: begin
        creq.start = 1'b1;
        creq.vectoring = 1'b0;
        creq.x = GAIN_INV_Q30;
        creq.z = ti;
      end
      BS_MUL_C: begin
        mul_a = c_r;
        mul_b = MB'($signed({1'b0, cfg.l3}));
      end
      BS_MUL_S: begin
        mul_a = s_r;
        mul_b = MB'($signed({1'b0, cfg.l3}));
      end
      BS_MUL_XX: begin
        mul_a = MA'(xw);
        mul_b = MB'(xw);
      end
      BS_MUL_YY: begin
        mul_a = MA'(yw);
        mul_b = MB'(yw);
      end
      BS_MUL_L11: begin
        mul_a = MA'($signed({1'b0, cfg.l1}));
        mul_b = MB'($signed({1'b0, cfg.l1}));
      end
      BS_MUL_L22: begin
        mul_a = MA'($signed({1'b0, cfg.l2}));
        mul_b = MB'($signed({1'b0, cfg.l2}));
      end
      BS_MUL_L12: begin
        mul_a = MA'($signed({1'b0, cfg.l1}));
        mul_b = MB'($signed({1'b0, cfg.l2}));
      end
      BS_MUL_DD: begin
        mul_a = MA'($signed({1'b0, den}));
        mul_b = MB'($signed({1'b0, den}));
      end
      BS_MUL_NN: begin
        mul_a = MA'(num_n);
        mul_b = num_n;
      end
      BS_ELBOW: begin
        creq.start = 1'b1;
        creq.x = CW'(num_n);
        creq.y = CW'($signed({1'b0, sq}));
      end
      BS_WDIR: begin
        creq.start = 1'b1;
        creq.x = CW'(xw);
        creq.y = CW'(yw);
      end
      BS_MUL_LS: begin
        mul_a = MA'($signed({1'b0, sq}));
        mul_b = MB'($signed({1'b0, cfg.l2}));
      end
      BS_MUL_LD: begin
        mul_a = MA'($signed({1'b0, den}));
        mul_b = MB'($signed({1'b0, cfg.l1}));
      end
      BS_MUL_LN: begin
        mul_a = MA'(num_n);
        mul_b = MB'($signed({1'b0, cfg.l2}));
      end
      BS_SHLD: begin
        creq.start = 1'b1;
        creq.x = xa;
        creq.y = ya;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BS_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == BS_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Multiplier output register.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Datapath: each state consumes the product launched in the state before.
  always_ff @(posedge clk) begin
    case (state)
      BS_IDLE: begin
        if (q_valid) begin
          xi <= q_item.x;
          yi <= q_item.y;
          thi <= q_item.th;
          ti <= q_item.t;
          negi <= q_item.neg;
          unreach <= 1'b0;
        end
      end
      BS_ROT_WAIT: begin
        if (crsp.done) begin
          c_r <= MA'(negi ? -crsp.x : crsp.x);
          s_r <= MA'(negi ? -crsp.y : crsp.y);
        end
      end
      BS_MUL_S:   xw <= WW'(xi) - WW'(prod_rnd);
      BS_MUL_XX:  yw <= WW'(yi) - WW'(prod_rnd);
      BS_MUL_YY:  num <= NW'(prod);
      BS_MUL_L11: num <= num + NW'(prod);
      BS_MUL_L22: num <= num - NW'(prod);
      BS_MUL_L12: num <= num - NW'(prod);
      BS_CHECK: begin
        den <= den_c;
        unreach <= unreach_c;
      end
      BS_MUL_NN: vacc <= SQ_IN_W'(prod);
      BS_SQRT_WAIT: begin
        if (sq_done) begin
          sq <= sq_root;
        end
      end
      BS_ELBOW_WAIT: begin
        if (crsp.done) begin
          q2z <= crsp.z;
        end
      end
      BS_WDIR_WAIT: begin
        if (crsp.done) begin
          q1a <= crsp.z;
        end
      end
      BS_MUL_LD:  ya <= CW'(prod);
      BS_MUL_LN:  xa <= CW'(prod);
      BS_MUL_SUM: xa <= xa + CW'(prod);
      BS_SHLD_WAIT: begin
        if (crsp.done) begin
          q1z <= 26'(q1a) - 26'(crsp.z);
        end
      end
      BS_FINISH: begin
        if (out_free) begin
          reachable <= !unreach;
          if (unreach) begin
            base_joint_angle <= '0;
            elbow_joint_angle <= '0;
            wrist_joint_angle <= '0;
          end else begin
            base_joint_angle <= sat18(q1o);
            elbow_joint_angle <= q2c;
            wrist_joint_angle <= sat18(q3w);
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

>>> sv/planar_three_link_inverse_kinematics_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// planar_three_link_inverse_kinematics_core: closed-form planar 3R arm IK
// Turns a tool target (x, y, angle) into base, elbow and wrist joint angles.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (target_x, target_y, tool_orientation) arrive on the
//   in_valid/in_ready channel; each gives one result word on out_valid/
//   out_ready. Link lengths and the base offset are written on the cfg
//   channel (cfg_ready is always high) while the core is idle.
//   A two-word queue sits in front of the solver, so new words are taken
//   while the solver works and while a finished word waits at the output.
//   Each word in the solver makes four passes through the one shared
//   CORDIC unit, plus a pass through the bit-serial square root and the
//   products of the shared multiplier. An atan2 of a zero vector skips
//   its pass. Out-of-reach words finish after the reach test, skipping
//   the square root and the later CORDIC passes. The sustained rate is
//   one word per solver pass, as long as the receiver does not stall.
//   Reset clears the queue and the output valid flag and loads the default
//   link lengths (0.4 m, 0.4 m, 0.2 m) and a pi/2 base offset. When the
//   receiver stalls, the result is held and the solver waits at its end.
// ----------------------------------------------------------------------------
module planar_three_link_inverse_kinematics_core import p3ik_pkg::*; #(
  parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] target_x,
  input  wire logic signed [15:0] target_y,
  input  wire logic signed [15:0] tool_orientation,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    reachable,
  output logic signed [17:0]      base_joint_angle,
  output logic [14:0]             elbow_joint_angle,
  output logic signed [17:0]      wrist_joint_angle,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  cfg_t    cfg;
  logic    q_valid;
  logic    q_ready;
  q_item_t q_item;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.l1 <= UPPER_RESET;
      cfg.l2 <= MIDDLE_RESET;
      cfg.l3 <= TOOL_RESET;
      cfg.off <= OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_UPPER:  cfg.l1 <= cfg_data[LW-1:0];
        REG_MIDDLE: cfg.l2 <= cfg_data[LW-1:0];
        REG_TOOL:   cfg.l3 <= cfg_data[LW-1:0];
        REG_OFFSET: cfg.off <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  p3ik_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .target_x         (target_x),
    .target_y         (target_y),
    .tool_orientation (tool_orientation),
    .q_valid          (q_valid),
    .q_ready          (q_ready),
    .q_item           (q_item)
  );

  p3ik_back #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .q_valid           (q_valid),
    .q_ready           (q_ready),
    .q_item            (q_item),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .reachable         (reachable),
    .base_joint_angle  (base_joint_angle),
    .elbow_joint_angle (elbow_joint_angle),
    .wrist_joint_angle (wrist_joint_angle)
  );

endmodule
`default_nettype wire
